@@ hw/rtl/url_percent_escape_normalizer_core_assert.svh @@
// ----------------------------------------------------------------------------
// url_percent_escape_normalizer_core_assert
// Assertion macros for the URL percent-escape normalizer.
// Each macro expects signals named clk and arst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_ESCAPE_NORMALIZER_CORE_ASSERT_SVH
`define URL_PERCENT_ESCAPE_NORMALIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define UPEN_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("upen assertion failed");
`define UPEN_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("upen forbidden condition seen");
`else
`define UPEN_ASSERT(lbl, prop)
`define UPEN_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hw/rtl/upen_pkg.sv @@
// ----------------------------------------------------------------------------
// upen_pkg
// Shared types, character constants and the byte class table of the
// percent-escape normalizer.
// ----------------------------------------------------------------------------
package upen_pkg;

	localparam logic [7:0] CHR_PCT      = 8'h25;
	localparam logic [1:0] CLS_RESERVED = 2'b01;
	localparam logic [1:0] CLS_UNSAFE   = 2'b10;
	localparam logic [3:0] NIB_MASK     = 4'hF;

	// One decision of the front: a byte sent as is, or sent as %XY.
	typedef struct packed {
		logic [7:0] data;
		logic       esc;
		logic       run_last;
		logic       str_end;
	} upen_tok_t;

	function automatic logic [1:0] char_class(input logic [7:0] c);
		logic [1:0] cls;
		if (c <= 8'h20 || c >= 8'h7f) begin
			cls = CLS_UNSAFE;
		end else begin
			case (c) inside
				8'h23, 8'h3a, 8'h40, 8'h5b, 8'h5d: begin
					cls = CLS_RESERVED | CLS_UNSAFE;
				end
				8'h26, 8'h2b, 8'h2f, 8'h3b, 8'h3d, 8'h3f: begin
					cls = CLS_RESERVED;
				end
				8'h22, 8'h25, 8'h3c, 8'h3e, 8'h5c, 8'h5e, 8'h60,
				8'h7b, 8'h7c, 8'h7d, 8'h7e: begin
					cls = CLS_UNSAFE;
				end
				default: begin
					cls = 2'b00;
				end
			endcase
		end
		return cls;
	endfunction

	// Unsafe but not reserved: goes out as an escape.
	function automatic logic needs_escape(input logic [7:0] c);
		logic [1:0] cls;
		cls = char_class(c);
		return ((cls & CLS_UNSAFE) != 2'b00) && ((cls & CLS_RESERVED) == 2'b00);
	endfunction

	// {is_hex, value}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		case (c) inside
			[8'h30:8'h39]: r = {1'b1, c[3:0]};
			[8'h41:8'h46], [8'h61:8'h66]: r = {1'b1, c[3:0] + 4'd9};
			default: r = 5'b0_0000;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [3:0] n;
		n = v & NIB_MASK;
		return (n < 4'd10) ? (8'h30 + {4'b0000, n}) : (8'h37 + {4'b0000, n});
	endfunction

endpackage

@@ hw/rtl/upen_front.sv @@
// ----------------------------------------------------------------------------
// upen_front
// Look-ahead window and escape decisions; holds up to three decisions of
// one input beat and hands them to the queue one per cycle unless it is full.
// ----------------------------------------------------------------------------
module upen_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output logic              q_push,
	output upen_pkg::upen_tok_t q_tok
);
	import upen_pkg::*;

	logic [7:0] win0_q, win1_q;
	logic [1:0] pend_q, skip_q;
	upen_tok_t  tok_q [3];
	logic [2:0] mask_q;

	logic       accept;
	logic [1:0] sel;
	logic [2:0] mask_left;

	// next window
	logic       pend2, main_emit, main_dec;
	logic [7:0] nw0, nw1;
	logic [1:0] npend, s1, s2;
	logic       emit0, emit1;
	logic [4:0] hx_a, hx_b;
	logic [7:0] dec_byte;
	upen_tok_t  t_main, t_f0, t_f1;
	logic [2:0] new_mask;

	always_comb begin
		if (mask_q[0]) sel = 2'd0;
		else if (mask_q[1]) sel = 2'd1;
		else sel = 2'd2;
	end

	assign q_push    = (mask_q != 3'b000) && !q_full;
	assign q_tok     = tok_q[sel];
	assign mask_left = mask_q & ~(3'b001 << sel);
	assign in_stall  = !((mask_q == 3'b000) || (q_push && (mask_left == 3'b000)));
	assign accept    = in_valid && !in_stall;

	always_comb begin
		pend2    = (pend_q == 2'd2);
		hx_a     = hex_val(win1_q);
		hx_b     = hex_val(in_byte);
		dec_byte = {hx_a[3:0], hx_b[3:0]};

		main_emit = pend2 && (skip_q == 2'd0);
		main_dec  = 1'b0;
		t_main    = '0;
		if (win0_q == CHR_PCT) begin
			if (hx_a[4] && hx_b[4]) begin
				if (char_class(dec_byte) == 2'b00) begin
					main_dec    = 1'b1;
					t_main.data = dec_byte;
				end else begin
					t_main.data = CHR_PCT;
				end
			end else begin
				t_main.data = CHR_PCT;
				t_main.esc  = 1'b1;
			end
		end else begin
			t_main.data = win0_q;
			t_main.esc  = needs_escape(win0_q);
		end

		if (pend2 && (skip_q != 2'd0)) s1 = skip_q - 2'd1;
		else if (main_emit && main_dec) s1 = 2'd2;
		else s1 = skip_q;

		if (pend2) begin
			nw0 = win1_q;  nw1 = in_byte; npend = 2'd2;
		end else if (pend_q == 2'd1) begin
			nw0 = win0_q;  nw1 = in_byte; npend = 2'd2;
		end else begin
			nw0 = in_byte; nw1 = win1_q;  npend = 2'd1;
		end

		// flush: no second look-ahead, so a percent sign always escapes
		emit0 = (s1 == 2'd0);
		s2    = (s1 != 2'd0) ? s1 - 2'd1 : s1;
		emit1 = (npend == 2'd2) && (s2 == 2'd0);
		t_f0  = '{data: nw0, esc: needs_escape(nw0), run_last: 1'b0, str_end: 1'b0};
		t_f1  = '{data: nw1, esc: needs_escape(nw1), run_last: 1'b0, str_end: 1'b0};

		new_mask = {in_last && emit1, in_last && emit0, main_emit};
		if (new_mask[2]) begin
			t_f1.run_last = 1'b1;
			t_f1.str_end  = in_last;
		end else if (new_mask[1]) begin
			t_f0.run_last = 1'b1;
			t_f0.str_end  = in_last;
		end else begin
			t_main.run_last = 1'b1;
			t_main.str_end  = in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'b000;
			win0_q <= 8'h00;
			win1_q <= 8'h00;
			pend_q <= 2'd0;
			skip_q <= 2'd0;
		end else begin
			if (accept) begin
				mask_q <= new_mask;
			end else if (q_push) begin
				mask_q <= mask_left;
			end
			if (accept) begin
				if (in_last) begin
					win0_q <= 8'h00;
					win1_q <= 8'h00;
					pend_q <= 2'd0;
					skip_q <= 2'd0;
				end else begin
					win0_q <= nw0;
					win1_q <= nw1;
					pend_q <= npend;
					skip_q <= s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_q[0] <= t_main;
			tok_q[1] <= t_f0;
			tok_q[2] <= t_f1;
		end
	end

endmodule

@@ hw/rtl/upen_queue.sv @@
// ----------------------------------------------------------------------------
// upen_queue
// Small decision queue between front and back.
// ----------------------------------------------------------------------------
`include "url_percent_escape_normalizer_core_assert.svh"

module upen_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  upen_pkg::upen_tok_t push_tok,
	output logic                full,
	input  logic                pop,
	output logic                pop_valid,
	output upen_pkg::upen_tok_t pop_tok
);
	import upen_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

	upen_tok_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == DEPTH_C);
	assign pop_valid = (cnt_q != '0);
	assign pop_tok   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_P) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_P) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_tok;
		end
	end

	`UPEN_ASSERT(a_no_overflow, push |-> !full)
	`UPEN_ASSERT(a_no_underflow, pop |-> pop_valid)
	`UPEN_ASSERT(a_cnt_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
	`UPEN_ASSERT_NEVER(a_cnt_bound, cnt_q > DEPTH_C)

endmodule

@@ hw/rtl/upen_back.sv @@
// ----------------------------------------------------------------------------
// upen_back
// Expands decisions into output beats: one byte, or '%' and two hex digits.
// ----------------------------------------------------------------------------
module upen_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  upen_pkg::upen_tok_t q_tok,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                string_end
);
	import upen_pkg::*;

	typedef enum logic [2:0] {
		PH_PCT = 3'b001,
		PH_HI  = 3'b010,
		PH_LO  = 3'b100
	} upen_phase_t;

	upen_tok_t   cur_q;
	upen_phase_t ph_q;
	logic        busy_q;
	logic        fin, advance;

	assign fin     = !cur_q.esc || (ph_q == PH_LO);
	assign advance = busy_q && !out_stall;
	assign q_pop   = q_valid && (!busy_q || (advance && fin));

	assign out_valid  = busy_q;
	assign run_last   = fin && cur_q.run_last;
	assign string_end = fin && cur_q.str_end;

	always_comb begin
		case (ph_q)
			PH_PCT:  out_byte = cur_q.esc ? CHR_PCT : cur_q.data;
			PH_HI:   out_byte = hex_digit(cur_q.data[7:4]);
			PH_LO:   out_byte = hex_digit(cur_q.data[3:0]);
			default: out_byte = cur_q.data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_PCT;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				ph_q   <= PH_PCT;
			end else if (advance) begin
				if (fin) begin
					busy_q <= 1'b0;
					ph_q   <= PH_PCT;
				end else begin
					case (ph_q)
						PH_PCT:  ph_q <= PH_HI;
						PH_HI:   ph_q <= PH_LO;
						default: ph_q <= PH_PCT;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_tok;
		end
	end

endmodule

@@ hw/rtl/url_percent_escape_normalizer_core.sv @@
// A byte is decided when the second byte after it arrives (or at the last
//   byte), then is registered in front, queue and back end. Throughput: one
//   output beat per cycle unless stalled, set by the back end's single output
//   register; an escape holds it for '%' and two hex digits, so unstalled
//   input runs one beat per cycle for plain text, plus up to 3 flush decisions.
// Reset: arst_n clears window, counters, queue and output valid at once.
// ----------------------------------------------------------------------------
// url_percent_escape_normalizer_core
// Streaming URL percent-escape normalizer: decode safe escapes, escape unsafe
// bytes, pass the rest.
// ----------------------------------------------------------------------------
module url_percent_escape_normalizer_core #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);
	import upen_pkg::*;

	// front to queue
	logic      fq_push, fq_full;
	upen_tok_t fq_tok;

	// queue to back
	logic      qb_pop, qb_valid;
	upen_tok_t qb_tok;

	// Front: hold the two-byte look-ahead window, decide each byte once its
	// look-ahead is in, drop the digits of a decoded escape, and flush the
	// window on the last beat. Stall input while decisions of the previous
	// beat still wait for the queue.
	upen_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (fq_full),
		.q_push   (fq_push),
		.q_tok    (fq_tok)
	);

	// Queue: decouple the front from output backpressure, so the front keeps
	// taking beats while the back end spells out an escape.
	upen_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_tok  (fq_tok),
		.full      (fq_full),
		.pop       (qb_pop),
		.pop_valid (qb_valid),
		.pop_tok   (qb_tok)
	);

	// Back: advance one output beat per cycle while out_stall is low; mark run
	// and string ends on the final beat of each decision.
	upen_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (qb_valid),
		.q_tok      (qb_tok),
		.q_pop      (qb_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule
